// ----- sv/dtp_pkg.sv -----
`default_nettype none
package dtp_pkg;

  localparam int POOL_SLOTS_DEF = 16;
  localparam int TIME_W         = 32;
  localparam int EVENT_W        = 16;
  localparam int STATUS_W       = 3;

  localparam logic [TIME_W-1:0] NO_DEADLINE = 32'hffff_ffff;

  typedef enum logic {
    ACT_TICK     = 1'b0,
    ACT_SCHEDULE = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_FIRED_PENDING = 3'd0,
    STS_EMPTY         = 3'd1,
    STS_NOT_DUE       = 3'd2,
    STS_FIRED_EMPTY   = 3'd3,
    STS_SCHEDULED     = 3'd4,
    STS_IMMEDIATE     = 3'd5,
    STS_FULL          = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_SCAN = 2'd1,
    FSM_DONE = 2'd2
  } fsm_t;

endpackage
`default_nettype wire

// ----- sv/dtp_ram.sv -----
`default_nettype none
module dtp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/delayed_event_timer_pool.sv -----
// Pool of one-shot delayed-event timers. A request is taken when start is high and busy
// is low. A schedule request, and a tick that finds the pool empty or not yet due, is
// answered by a single closing status item in the cycle after it is taken, and the next
// request may follow at once. A tick that is due walks the slot memory one slot per
// cycle; busy stays high until its closing status item comes out. Fired events come out in
// slot order as they are read; after the last read the closing item passes the slot check
// and the DONE state. Results are strobed by out_valid for one cycle and must be taken in
// that cycle; the receiver cannot stall the block. Slot contents sit in one memory with a
// registered read; only the busy flags are held in flip-flops.
`default_nettype none
module delayed_event_timer_pool #(
  parameter int POOL_SLOTS = dtp_pkg::POOL_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_action,
  input  wire logic [dtp_pkg::TIME_W-1:0]    in_now_ms,
  input  wire logic [dtp_pkg::EVENT_W-1:0]   in_event_id,
  input  wire logic [dtp_pkg::TIME_W-1:0]    in_delay_ms,
  output logic                               out_valid,
  output logic                               out_has_event,
  output logic      [dtp_pkg::EVENT_W-1:0]   out_event_out,
  output logic      [dtp_pkg::STATUS_W-1:0]  out_status,
  output logic                               out_last
);

  import dtp_pkg::*;

  localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
  localparam int ENTRY_W = EVENT_W + TIME_W;

  fsm_t                    state_r, state_nxt;
  logic [POOL_SLOTS-1:0]   busy_r, busy_nxt;
  logic [TIME_W-1:0]       earliest_r, earliest_nxt;
  logic                    empty_r, empty_nxt;
  logic [CNT_W-1:0]        issue_cnt_r, issue_cnt_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  logic [SLOT_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic [TIME_W-1:0]       now_r, now_nxt;
  logic [TIME_W-1:0]       min_acc_r, min_acc_nxt;
  logic                    keep_acc_r, keep_acc_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_has_event_r, out_has_event_nxt;
  logic [EVENT_W-1:0]      out_event_r, out_event_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic [EVENT_W-1:0]      rd_event;
  logic [TIME_W-1:0]       rd_deadline;

  logic                    accept;
  logic                    issue;
  logic                    free_found;
  logic [SLOT_W-1:0]       free_idx;
  logic [TIME_W-1:0]       new_deadline;

  assign accept       = start && (state_r == FSM_IDLE);
  assign issue        = (state_r == FSM_SCAN) && (issue_cnt_r < CNT_W'(POOL_SLOTS));
  assign new_deadline = in_now_ms + in_delay_ms;
  assign rd_event     = ram_rdata[ENTRY_W-1:TIME_W];
  assign rd_deadline  = ram_rdata[TIME_W-1:0];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      if (!free_found && !busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  dtp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_SLOTS),
    .AW    (SLOT_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_cnt_r[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt         = state_r;
    busy_nxt          = busy_r;
    earliest_nxt      = earliest_r;
    empty_nxt         = empty_r;
    issue_cnt_nxt     = issue_cnt_r;
    chk_vld_nxt       = issue;
    chk_idx_nxt       = issue_cnt_r[SLOT_W-1:0];
    now_nxt           = now_r;
    min_acc_nxt       = min_acc_r;
    keep_acc_nxt      = keep_acc_r;
    out_valid_nxt     = 1'b0;
    out_has_event_nxt = 1'b0;
    out_event_nxt     = '0;
    out_status_nxt    = STS_FIRED_PENDING;
    out_last_nxt      = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = free_idx;
    ram_wdata         = {in_event_id, new_deadline};

    if (issue) begin
      issue_cnt_nxt = issue_cnt_r + CNT_W'(1);
    end

    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (action_t'(in_action) == ACT_SCHEDULE) begin
            if (in_delay_ms == '0) begin
              out_has_event_nxt = 1'b1;
              out_event_nxt     = in_event_id;
              out_status_nxt    = STS_IMMEDIATE;
            end else if (!free_found) begin
              out_status_nxt = STS_FULL;
            end else begin
              ram_we             = 1'b1;
              busy_nxt[free_idx] = 1'b1;
              empty_nxt          = 1'b0;
              if (empty_r || (new_deadline < earliest_r)) begin
                earliest_nxt = new_deadline;
              end
              out_status_nxt = STS_SCHEDULED;
            end
          end else if (empty_r) begin
            out_status_nxt = STS_EMPTY;
          end else if (in_now_ms < earliest_r) begin
            out_status_nxt = STS_NOT_DUE;
          end else begin
            out_valid_nxt = 1'b0;
            out_last_nxt  = 1'b0;
            state_nxt     = FSM_SCAN;
            issue_cnt_nxt = '0;
            now_nxt       = in_now_ms;
            min_acc_nxt   = NO_DEADLINE;
            keep_acc_nxt  = 1'b0;
          end
        end
      end
      FSM_SCAN: begin
        if (chk_vld_r && busy_r[chk_idx_r]) begin
          if (rd_deadline <= now_r) begin
            busy_nxt[chk_idx_r] = 1'b0;
            out_valid_nxt       = 1'b1;
            out_has_event_nxt   = 1'b1;
            out_event_nxt       = rd_event;
          end else begin
            keep_acc_nxt = 1'b1;
            if (rd_deadline < min_acc_r) begin
              min_acc_nxt = rd_deadline;
            end
          end
        end
        if (chk_vld_r && (chk_idx_r == SLOT_W'(POOL_SLOTS - 1))) begin
          state_nxt = FSM_DONE;
        end
      end
      FSM_DONE: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        empty_nxt     = !keep_acc_r;
        if (keep_acc_r) begin
          earliest_nxt   = min_acc_r;
          out_status_nxt = STS_FIRED_PENDING;
        end else begin
          out_status_nxt = STS_FIRED_EMPTY;
        end
        state_nxt = FSM_IDLE;
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      busy_r      <= '0;
      earliest_r  <= '0;
      empty_r     <= 1'b1;
      issue_cnt_r <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      earliest_r  <= earliest_nxt;
      empty_r     <= empty_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r       <= chk_idx_nxt;
    now_r           <= now_nxt;
    min_acc_r       <= min_acc_nxt;
    keep_acc_r      <= keep_acc_nxt;
    out_has_event_r <= out_has_event_nxt;
    out_event_r     <= out_event_nxt;
    out_status_r    <= out_status_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign busy          = (state_r != FSM_IDLE);
  assign out_valid     = out_valid_r;
  assign out_has_event = out_has_event_r;
  assign out_event_out = out_event_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  a_done_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_DONE) |=> (out_valid && out_last))
    else $error("Closing status item missing after the scan.");

  a_schedule_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action == ACT_SCHEDULE)) |=> (out_valid && out_last && !busy))
    else $error("Schedule request not answered in the following cycle.");

  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_event && (out_status != STS_IMMEDIATE)) |-> !out_last)
    else $error("Fired event marked as the closing item.");

  a_check_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (state_r == FSM_SCAN))
    else $error("Slot check outside the scan.");

  a_empty_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (empty_r && (state_r == FSM_IDLE)) |-> (busy_r == '0))
    else $error("Pool marked empty while a slot is busy.");

endmodule
`default_nettype wire

// ----- verif/tb_delayed_event_timer_pool.sv -----
`timescale 1ns / 1ps

module testbench;
  import dtp_pkg::*;

  localparam int SLOTS           = POOL_SLOTS_DEF;
  localparam int RANDOM_REQUESTS = 232;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = SLOTS + 8;

  typedef struct {
    logic                 has_event;
    logic [EVENT_W-1:0]   event_id;
    status_t              status;
    logic                 last;
  } timer_result_t;

  typedef struct {
    action_t              act;
    logic [TIME_W-1:0]    now_ms;
    logic [EVENT_W-1:0]   event_id;
    logic [TIME_W-1:0]    delay_ms;
    bit                   fixed;
    logic                 has_event;
    logic [EVENT_W-1:0]   event_out;
    status_t              status;
  } timer_request_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_action;
  logic [TIME_W-1:0]    in_now_ms;
  logic [EVENT_W-1:0]   in_event_id;
  logic [TIME_W-1:0]    in_delay_ms;
  logic                 out_valid;
  logic                 out_has_event;
  logic [EVENT_W-1:0]   out_event_out;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_last;

  timer_result_t        awaited_results[$];
  int                   error_count = 0;
  int                   cycle_count = 0;
  int                   burst_left  = 0;
  logic [TIME_W-1:0]    clock_ms    = '0;

  bit                   slot_taken    [SLOTS];
  logic [EVENT_W-1:0]   slot_signal   [SLOTS];
  logic [TIME_W-1:0]    slot_due      [SLOTS];
  logic [TIME_W-1:0]    soonest_due   = '0;
  bit                   pool_idle     = 1'b1;

  // Directed requests; rows marked fixed carry a result that is plain from the behaviour.
  timer_request_t directed_plan[28] = '{
    '{ACT_TICK,     32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_TICK,     32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000, 1'b1, 1'b1, 16'hFFFF, STS_IMMEDIATE},
    '{ACT_SCHEDULE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, 16'h0000, STS_IMMEDIATE},
    '{ACT_SCHEDULE, 32'hFFFF_FFF0, 16'h1234, 32'h0000_0020, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_TICK,     32'h0000_0005, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_TICK,     32'h0000_0010, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_TICK,     32'hFFFF_FFFF, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_TICK,     32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h8000, 32'h0000_0010, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h8001, 32'h0000_000F, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h8002, 32'h0000_000E, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h8003, 32'h0000_000D, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h8004, 32'h0000_000C, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h8005, 32'h0000_000B, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h8006, 32'h0000_000A, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h8007, 32'h0000_0009, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h8008, 32'h0000_0008, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h8009, 32'h0000_0007, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h800A, 32'h0000_0006, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h800B, 32'h0000_0005, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h800C, 32'h0000_0004, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h800D, 32'h0000_0003, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h800E, 32'h0000_0002, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h800F, 32'h0000_0001, 1'b0, 1'b0, 16'h0000, STS_EMPTY},
    '{ACT_SCHEDULE, 32'h0000_0100, 16'h5555, 32'h0000_0007, 1'b1, 1'b0, 16'h0000, STS_FULL},
    '{ACT_TICK,     32'h0000_0110, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, STS_EMPTY}
  };

  delayed_event_timer_pool #(
    .POOL_SLOTS(SLOTS)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_now_ms    (in_now_ms),
    .in_event_id  (in_event_id),
    .in_delay_ms  (in_delay_ms),
    .out_valid    (out_valid),
    .out_has_event(out_has_event),
    .out_event_out(out_event_out),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void expect_result(logic has_event, logic [EVENT_W-1:0] event_id,
                                        status_t status, logic last);
    timer_result_t item;
    item.has_event = has_event;
    item.event_id  = event_id;
    item.status    = status;
    item.last      = last;
    awaited_results.push_back(item);
  endfunction

  function automatic void refresh_soonest_due();
    logic [TIME_W-1:0] lowest;
    lowest = NO_DEADLINE;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_taken[i] && slot_due[i] < lowest) lowest = slot_due[i];
    end
    soonest_due = lowest;
  endfunction

  function automatic void predict_timer_response(timer_request_t req);
    int  free_slot;
    bit  emptied;
    free_slot = -1;
    emptied   = 1'b1;
    if (req.act == ACT_SCHEDULE) begin
      if (req.delay_ms == '0) begin
        expect_result(1'b1, req.event_id, STS_IMMEDIATE, 1'b1);
        return;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_taken[i] && free_slot < 0) free_slot = i;
      end
      if (free_slot < 0) begin
        expect_result(1'b0, '0, STS_FULL, 1'b1);
        return;
      end
      slot_taken[free_slot]  = 1'b1;
      slot_signal[free_slot] = req.event_id;
      slot_due[free_slot]    = req.now_ms + req.delay_ms;
      pool_idle              = 1'b0;
      refresh_soonest_due();
      expect_result(1'b0, '0, STS_SCHEDULED, 1'b1);
    end else if (pool_idle) begin
      expect_result(1'b0, '0, STS_EMPTY, 1'b1);
    end else if (req.now_ms < soonest_due) begin
      expect_result(1'b0, '0, STS_NOT_DUE, 1'b1);
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_taken[i]) begin
          if (slot_due[i] > req.now_ms) begin
            emptied = 1'b0;
          end else begin
            expect_result(1'b1, slot_signal[i], STS_FIRED_PENDING, 1'b0);
            slot_taken[i] = 1'b0;
          end
        end
      end
      pool_idle = emptied;
      if (emptied) begin
        expect_result(1'b0, '0, STS_FIRED_EMPTY, 1'b1);
      end else begin
        refresh_soonest_due();
        expect_result(1'b0, '0, STS_FIRED_PENDING, 1'b1);
      end
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic issue_request(timer_request_t req);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
    end
    in_action   = req.act;
    in_now_ms   = req.now_ms;
    in_event_id = req.event_id;
    in_delay_ms = req.delay_ms;
    start       = 1'b1;
    burst_left--;
    do @(posedge clk); while (busy);
    predict_timer_response(req);
    if (req.fixed) begin
      void'(awaited_results.pop_back());
      expect_result(req.has_event, req.event_out, req.status, 1'b1);
    end
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    start = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic timer_request_t random_request(int index);
    timer_request_t req;
    int             pick;
    pick          = $urandom_range(0, 99);
    req.fixed     = 1'b0;
    req.has_event = 1'b0;
    req.event_out = '0;
    req.status    = STS_EMPTY;
    req.event_id  = EVENT_W'($urandom);
    req.delay_ms  = $urandom;
    req.now_ms    = clock_ms;
    req.act       = ACT_SCHEDULE;
    // Every so often a run of long schedules fills the pool.
    if (index % 80 >= 40 && index % 80 < 58) begin
      req.delay_ms = $urandom_range(30, 300);
    end else if (pick < 35) begin
      req.delay_ms = $urandom_range(1, 60);
    end else if (pick < 40) begin
      req.now_ms = clock_ms;
    end else if (pick < 47) begin
      req.now_ms   = $urandom;
      req.delay_ms = '0;
    end else if (pick < 90) begin
      clock_ms   = clock_ms + $urandom_range(0, 12);
      req.act    = ACT_TICK;
      req.now_ms = clock_ms;
    end else begin
      clock_ms   = $urandom;
      req.act    = ACT_TICK;
      req.now_ms = clock_ms;
    end
    return req;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected: has_event %b event %h status %0d last %b",
                 $time, out_has_event, out_event_out, out_status, out_last);
      end else begin
        want = awaited_results.pop_front();
        check_field("has_event", 32'(want.has_event), 32'(out_has_event));
        check_field("event_out", 32'(want.event_id), 32'(out_event_out));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("delayed_event_timer_pool: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_action   = ACT_TICK;
    in_now_ms   = '0;
    in_event_id = '0;
    in_delay_ms = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_plan[i]) issue_request(directed_plan[i]);
    wait_for_results();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 2) wait_for_results();
      issue_request(random_request(n));
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("delayed_event_timer_pool: match");
    end else begin
      $display("delayed_event_timer_pool: mismatch");
    end
    $finish;
  end

endmodule
